### hw/rtl/lfu_cache_policy_assert.svh
// Assertion macros for the LFU cache policy block.
// Used by lfu_cache_policy.sv; expects clk and arst_n in scope.
`ifndef LFU_CACHE_POLICY_ASSERT_SVH
`define LFU_CACHE_POLICY_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define LFU_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Trigger this cycle implies consequence on the next cycle.
`define LFU_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/lfu_pkg.sv
// Package for the LFU cache policy block: request/response types, entry layout,
// scan states and constants. No dependencies.
package lfu_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int KEY_W           = 32;
	localparam int VAL_W           = 32;
	localparam int CNT_W           = 16;
	localparam int STAMP_W         = 32;
	localparam int CAP_W           = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
	localparam logic [CNT_W-1:0] COUNT_ONE = 16'd1;
	localparam logic [VAL_W-1:0] MISS_VAL  = 32'hFFFF_FFFF;

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	typedef struct packed {
		logic              command;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic signed [VAL_W-1:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
		logic [CNT_W-1:0]   count;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_COMMIT
	} state_t;

endpackage

### hw/rtl/lfu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/lfu_cache_policy.sv
// Least-frequently-used key-value store with oldest-touch tie-break on eviction.
// Depends on lfu_pkg, lfu_ram and lfu_cache_policy_assert.svh.
//
// Each request (get or put) is handled in steps before the next is accepted:
// the entry RAM has one read port, so the block walks every slot once, one read a
// cycle, to find the key, the least-used victim and the first free slot; then the
// FLUSH state takes the registered read of the last slot and the COMMIT state the
// single write-back, and the block returns to idle before taking the next request.
// The response sits in an output register, so the next request is taken while it
// waits; that request's write-back then holds until the register drains. Valid
// bits live in flops and are cleared by reset; the RAM needs no clearing pass.
// Write capacity only while no request is in flight.
module lfu_cache_policy #(
	parameter int MAX_ENTRIES = lfu_pkg::MAX_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  lfu_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output lfu_pkg::rsp_t               rsp,
	input  logic                        cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]   cfg_data
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int OW = (CW > lfu_pkg::CAP_W) ? CW : lfu_pkg::CAP_W;
	localparam int EW = $bits(lfu_pkg::entry_t);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);
	localparam logic [OW-1:0] MAX_O    = OW'(MAX_ENTRIES);

	lfu_pkg::state_t state_q, state_d;

	logic [lfu_pkg::CAP_W-1:0]   cap_q;
	logic [MAX_ENTRIES-1:0]      valid_q;
	logic [CW-1:0]               occ_q;
	logic [lfu_pkg::STAMP_W-1:0] clock_q;

	lfu_pkg::req_t               req_q;
	logic [lfu_pkg::STAMP_W-1:0] stamp_q;
	logic [IW-1:0]               scan_q;
	logic                        rd_v_s1;
	logic [IW-1:0]               rd_idx_s1;

	logic                        found_q;
	logic [IW-1:0]               found_idx_q;
	lfu_pkg::entry_t             found_ent_q;
	logic                        vic_q;
	logic [IW-1:0]               vic_idx_q;
	logic [lfu_pkg::CNT_W-1:0]   vic_cnt_q;
	logic [lfu_pkg::STAMP_W-1:0] vic_stamp_q;
	logic                        free_q;
	logic [IW-1:0]               free_idx_q;

	logic                        rsp_valid_q;
	lfu_pkg::rsp_t               rsp_q;

	logic [EW-1:0]               ram_rdata;
	lfu_pkg::entry_t             rd_ent;
	lfu_pkg::entry_t             wr_ent;
	logic                        ram_we;
	logic [IW-1:0]               ram_waddr;

	logic                        accept;
	logic                        out_free;
	logic                        commit;
	logic                        rd_live;
	logic                        is_put;
	logic [OW-1:0]               eff_cap;
	logic                        evict;
	logic                        insert;
	logic [IW-1:0]               slot;
	lfu_pkg::rsp_t               rsp_d;

	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != lfu_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rd_ent    = lfu_pkg::entry_t'(ram_rdata);
	assign rd_live   = rd_v_s1 && valid_q[rd_idx_s1];
	assign is_put    = (req_q.command == lfu_pkg::CMD_PUT);

	lfu_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_ENTRIES),
		.AW    (IW)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_ent),
		.raddr (scan_q),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lfu_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = lfu_pkg::ST_SCAN;
				end
			end
			lfu_pkg::ST_SCAN: begin
				if (scan_q == LAST_IDX) begin
					state_d = lfu_pkg::ST_FLUSH;
				end
			end
			lfu_pkg::ST_FLUSH: begin
				state_d = lfu_pkg::ST_COMMIT;
			end
			lfu_pkg::ST_COMMIT: begin
				if (out_free) begin
					state_d = lfu_pkg::ST_IDLE;
				end
			end
			default: state_d = lfu_pkg::ST_IDLE;
		endcase
	end

	// commit decision, write-back and response
	always_comb begin
		commit = (state_q == lfu_pkg::ST_COMMIT) && out_free;

		if (cap_q == '0) begin
			eff_cap = OW'(1);
		end else if (OW'(cap_q) > MAX_O) begin
			eff_cap = MAX_O;
		end else begin
			eff_cap = OW'(cap_q);
		end

		evict  = !found_q && is_put && (OW'(occ_q) >= eff_cap) && vic_q;
		insert = !found_q && is_put && (evict || free_q);
		// victim slot frees up; the lowest free index wins
		if (evict && (!free_q || vic_idx_q < free_idx_q)) begin
			slot = vic_idx_q;
		end else begin
			slot = free_idx_q;
		end

		wr_ent = found_ent_q;
		if (found_q) begin
			if (is_put) begin
				wr_ent.value = req_q.value;
			end
			if (found_ent_q.count != lfu_pkg::COUNT_MAX) begin
				wr_ent.count = found_ent_q.count + lfu_pkg::COUNT_ONE;
			end
			wr_ent.stamp = stamp_q;
			ram_waddr    = found_idx_q;
		end else begin
			wr_ent.key   = req_q.key;
			wr_ent.value = req_q.value;
			wr_ent.count = lfu_pkg::COUNT_ONE;
			wr_ent.stamp = stamp_q;
			ram_waddr    = slot;
		end
		ram_we = commit && (found_q || insert);

		rsp_d.hit = found_q;
		if (is_put) begin
			rsp_d.read_value = '0;
		end else if (found_q) begin
			rsp_d.read_value = found_ent_q.value;
		end else begin
			rsp_d.read_value = lfu_pkg::MISS_VAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lfu_pkg::ST_IDLE;
			cap_q       <= lfu_pkg::CAP_RESET;
			valid_q     <= '0;
			occ_q       <= '0;
			clock_q     <= '0;
			scan_q      <= '0;
			rd_v_s1     <= 1'b0;
			found_q     <= 1'b0;
			vic_q       <= 1'b0;
			free_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= (state_q == lfu_pkg::ST_SCAN);

			if (cfg_we) begin
				cap_q <= cfg_data;
			end

			if (accept) begin
				clock_q <= clock_q + 1'b1;
				scan_q  <= '0;
				found_q <= 1'b0;
				vic_q   <= 1'b0;
				free_q  <= 1'b0;
			end else if (state_q == lfu_pkg::ST_SCAN && scan_q != LAST_IDX) begin
				scan_q <= scan_q + 1'b1;
			end

			if (rd_live && !found_q && rd_ent.key == req_q.key) begin
				found_q <= 1'b1;
			end
			if (rd_live && (!vic_q || rd_ent.count < vic_cnt_q ||
			    (rd_ent.count == vic_cnt_q && rd_ent.stamp < vic_stamp_q))) begin
				vic_q <= 1'b1;
			end
			if (rd_v_s1 && !valid_q[rd_idx_s1]) begin
				free_q <= 1'b1;
			end

			if (commit) begin
				if (insert) begin
					if (!evict) begin
						occ_q <= occ_q + 1'b1;
					end else if (slot != vic_idx_q) begin
						valid_q[vic_idx_q] <= 1'b0;
					end
					valid_q[slot] <= 1'b1;
				end
			end

			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q;
		if (accept) begin
			req_q   <= req;
			stamp_q <= clock_q;
		end
		if (rd_live && !found_q && rd_ent.key == req_q.key) begin
			found_idx_q <= rd_idx_s1;
			found_ent_q <= rd_ent;
		end
		if (rd_live && (!vic_q || rd_ent.count < vic_cnt_q ||
		    (rd_ent.count == vic_cnt_q && rd_ent.stamp < vic_stamp_q))) begin
			vic_idx_q   <= rd_idx_s1;
			vic_cnt_q   <= rd_ent.count;
			vic_stamp_q <= rd_ent.stamp;
		end
		if (rd_v_s1 && !valid_q[rd_idx_s1] && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

`include "lfu_cache_policy_assert.svh"

	`LFU_ASSERT_ALWAYS(a_occ_matches_valid, occ_q == CW'($countones(valid_q)), "occupancy out of step with valid bits")
	`LFU_ASSERT_ALWAYS(a_occ_bound, OW'(occ_q) <= MAX_O, "occupancy above entry count")
	`LFU_ASSERT_NEXT(a_accept_starts_scan, accept, state_q == lfu_pkg::ST_SCAN && scan_q == '0, "request did not start a scan")
	`LFU_ASSERT_NEXT(a_commit_responds, commit, rsp_valid_q, "commit without response")

endmodule

### sim/lfu_cache_policy_tb.sv
// Self-checking testbench for lfu_cache_policy: directed and random get/put requests
// over a range of capacity settings, checked against an in-bench LFU/LRU predictor.
// Depends on lfu_pkg and the lfu_cache_policy RTL.
`timescale 1ns / 1ps

module lfu_cache_policy_tb;

	localparam int SLOTS        = lfu_pkg::MAX_ENTRIES_DEF;
	localparam int POOL_SIZE    = 24;
	localparam int RANDOM_ITEMS = 1150;
	localparam int HOLD_AFTER   = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 500000;

	class lfu_scoreboard;
		bit                                slot_valid[SLOTS];
		logic [lfu_pkg::KEY_W-1:0]         slot_key[SLOTS];
		logic [lfu_pkg::VAL_W-1:0]         slot_value[SLOTS];
		logic [lfu_pkg::CNT_W-1:0]         slot_count[SLOTS];
		logic [lfu_pkg::STAMP_W-1:0]       slot_stamp[SLOTS];
		logic [lfu_pkg::STAMP_W-1:0]       touch_clock;
		logic [lfu_pkg::CAP_W-1:0]         capacity;
		lfu_pkg::rsp_t                     pending_rsp[$];
		int                                mismatches;
		int                                responses;
		int                                requests;
		int                                hits;
		int                                evictions;

		function new();
			foreach (slot_valid[i])
				slot_valid[i] = 1'b0;
			touch_clock = '0;
			capacity    = lfu_pkg::CAP_RESET;
			mismatches  = 0;
			responses   = 0;
			requests    = 0;
			hits        = 0;
			evictions   = 0;
		endfunction

		function void set_capacity(logic [lfu_pkg::CAP_W-1:0] c);
			capacity = c;
		endfunction

		// zero acts as one, anything past the slot count acts as the slot count
		function int usable_slots();
			if (capacity == 0)
				return 1;
			if (capacity > SLOTS)
				return SLOTS;
			return capacity;
		endfunction

		function void note_request(lfu_pkg::req_t r);
			logic [lfu_pkg::STAMP_W-1:0] stamp;
			lfu_pkg::rsp_t               want;
			int                          found;
			int                          victim;
			int                          free_slot;
			int                          occupied;

			stamp = touch_clock;
			touch_clock = touch_clock + 1'b1;
			requests++;
			found = -1;
			for (int i = 0; i < SLOTS; i++)
				if (found < 0 && slot_valid[i] && slot_key[i] == r.key)
					found = i;
			want.hit = 1'b0;
			want.read_value = '0;
			if (found >= 0) begin
				want.hit = 1'b1;
				hits++;
				if (r.command == lfu_pkg::CMD_GET)
					want.read_value = slot_value[found];
				else
					slot_value[found] = r.value;
				if (slot_count[found] != lfu_pkg::COUNT_MAX)
					slot_count[found] = slot_count[found] + 1'b1;
				slot_stamp[found] = stamp;
			end else if (r.command == lfu_pkg::CMD_GET) begin
				want.read_value = lfu_pkg::MISS_VAL;
			end else begin
				occupied = 0;
				foreach (slot_valid[i])
					if (slot_valid[i])
						occupied++;
				// one victim only, even when capacity dropped below occupancy
				if (occupied >= usable_slots()) begin
					victim = -1;
					for (int i = 0; i < SLOTS; i++)
						if (slot_valid[i] && (victim < 0 ||
								slot_count[i] < slot_count[victim] ||
								(slot_count[i] == slot_count[victim] &&
								 slot_stamp[i] < slot_stamp[victim])))
							victim = i;
					if (victim >= 0) begin
						slot_valid[victim] = 1'b0;
						evictions++;
					end
				end
				free_slot = -1;
				for (int i = 0; i < SLOTS; i++)
					if (free_slot < 0 && !slot_valid[i])
						free_slot = i;
				if (free_slot >= 0) begin
					slot_valid[free_slot] = 1'b1;
					slot_key[free_slot]   = r.key;
					slot_value[free_slot] = r.value;
					slot_count[free_slot] = lfu_pkg::COUNT_ONE;
					slot_stamp[free_slot] = stamp;
				end
			end
			pending_rsp.push_back(want);
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			if (mismatches < 40)
				$display("[%0t] response %0d: %s got %h expected %h",
					$time, responses, what, got, want);
			mismatches++;
		endtask

		task check_response(lfu_pkg::rsp_t got);
			lfu_pkg::rsp_t want;

			if (pending_rsp.size() == 0) begin
				report_mismatch("response with no request pending", got.read_value, '0);
				return;
			end
			want = pending_rsp.pop_front();
			responses++;
			if (got.hit !== want.hit)
				report_mismatch("hit", 32'(got.hit), 32'(want.hit));
			if (got.read_value !== want.read_value)
				report_mismatch("read_value", got.read_value, want.read_value);
		endtask
	endclass

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      req_valid = 1'b0;
	logic                      req_stall;
	lfu_pkg::req_t             req       = '0;
	logic                      rsp_valid;
	logic                      rsp_stall = 1'b0;
	lfu_pkg::rsp_t             rsp;
	logic                      cfg_we    = 1'b0;
	logic [lfu_pkg::CAP_W-1:0] cfg_data  = lfu_pkg::CAP_RESET;

	lfu_scoreboard             sb = new();
	logic [lfu_pkg::KEY_W-1:0] key_pool[POOL_SIZE];
	int                        pool_span = POOL_SIZE;
	int                        burst_left = 0;
	int                        cycle_count = 0;
	int                        hold_left = 0;
	bit                        hold_started = 1'b0;
	int                        stall_mode = 0;
	int                        pattern_left = 0;
	int                        phases_run = 0;

	lfu_cache_policy u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_count, sb.pending_rsp.size());
			$display("FAILURE");
			$finish;
		end
	end

	// response side: check, then pick the next stall value
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
		if (!hold_started && sb.responses >= HOLD_AFTER) begin
			hold_started = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (pattern_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			pattern_left = $urandom_range(16, 96);
		end else begin
			pattern_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 3) == 0);
				2: rsp_stall <= ($urandom_range(0, 3) != 0);
				default: rsp_stall <= ~rsp_stall;
			endcase
		end
	end

	// leaves valid high; the caller lowers it for a gap
	task send_request(lfu_pkg::req_t r);
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(r);
	endtask

	task issue(logic cmd, logic [lfu_pkg::KEY_W-1:0] k, logic [lfu_pkg::VAL_W-1:0] v);
		lfu_pkg::req_t r;

		r.command = cmd;
		r.key = k;
		r.value = v;
		send_request(r);
	endtask

	task wait_idle();
		while (sb.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 6) @(posedge clk);
	endtask

	task write_capacity(logic [lfu_pkg::CAP_W-1:0] c);
		cfg_we <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(c);
	endtask

	function logic [lfu_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// mostly keys from a small pool so gets hit and puts collide
	function lfu_pkg::req_t make_request();
		lfu_pkg::req_t r;

		r.command = $urandom_range(0, 1) ? lfu_pkg::CMD_PUT : lfu_pkg::CMD_GET;
		if ($urandom_range(0, 4) == 0)
			r.key = $urandom;
		else
			r.key = key_pool[$urandom_range(0, pool_span - 1)];
		r.value = pick_value();
		return r;
	endfunction

	task run_random(int count);
		int gap;

		for (int n = 0; n < count; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
				if (gap > 0) begin
					req_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			send_request(make_request());
			burst_left--;
		end
		req_valid <= 1'b0;
	endtask

	initial begin
		logic [lfu_pkg::CAP_W-1:0] caps[] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd12, 5'd3,
			5'd8, 5'd2, 5'd16, 5'd5, 5'd24, 5'd16};
		int span;

		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = '0;
		key_pool[3] = '1;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// extremes at the reset capacity: miss, inserts, hits, update
		issue(lfu_pkg::CMD_GET, 32'h8000_0000, 32'h1234_5678);
		issue(lfu_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		issue(lfu_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		issue(lfu_pkg::CMD_PUT, 32'h0000_0000, 32'h0000_0000);
		issue(lfu_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(lfu_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000);
		issue(lfu_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		issue(lfu_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
		issue(lfu_pkg::CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		issue(lfu_pkg::CMD_GET, 32'h0000_0005, 32'h0000_0000);
		req_valid <= 1'b0;
		wait_idle();

		// capacity dropped below occupancy: one eviction per new key
		write_capacity(5'd2);
		issue(lfu_pkg::CMD_PUT, 32'h0000_0007, 32'hA5A5_A5A5);
		issue(lfu_pkg::CMD_PUT, 32'h0000_0008, 32'h5A5A_5A5A);
		issue(lfu_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000);
		issue(lfu_pkg::CMD_GET, 32'h0000_0008, 32'h0000_0000);
		req_valid <= 1'b0;
		wait_idle();

		// zero capacity acts as one
		write_capacity(5'd0);
		issue(lfu_pkg::CMD_PUT, 32'h0000_0009, 32'h0000_0009);
		issue(lfu_pkg::CMD_PUT, 32'h0000_000A, 32'h0000_000A);
		issue(lfu_pkg::CMD_GET, 32'h0000_0009, 32'h0000_0000);
		issue(lfu_pkg::CMD_GET, 32'h0000_000A, 32'h0000_0000);
		req_valid <= 1'b0;
		wait_idle();

		// above the slot count acts as the slot count
		write_capacity(5'd31);
		issue(lfu_pkg::CMD_PUT, 32'h0000_000B, 32'h0000_000B);
		issue(lfu_pkg::CMD_PUT, 32'h0000_000C, 32'h0000_000C);
		req_valid <= 1'b0;
		wait_idle();

		foreach (caps[p]) begin
			write_capacity(caps[p]);
			span = sb.usable_slots() + 6;
			pool_span = (span > POOL_SIZE) ? POOL_SIZE : span;
			for (int i = 0; i < 4; i++)
				key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
			run_random(RANDOM_ITEMS / caps.size());
			wait_idle();
			phases_run++;
		end

		repeat (2 * (SLOTS + 3)) @(posedge clk);
		$display("covered %0d requests (%0d hits, %0d evictions) over %0d random phases",
			sb.requests, sb.hits, sb.evictions, phases_run);
		$display("capacities 0, 1 to 16 and past 16 used; one receiver hold of %0d cycles",
			HOLD_CYCLES);
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
